### src/ptagd_pkg.sv
// ----------------------------------------------------------------------------
// ptagd_pkg: shared types and constants of the priority task agenda
// control link between neighboring cells, state codes and register map
// ----------------------------------------------------------------------------
package ptagd_pkg;

    // field widths of one word, the limit register and the apb port
    localparam int PRI_W     = 16;
    localparam int OUT_HW    = 16;
    localparam int LIMIT_W   = 5;
    localparam int DATA_W    = PRI_W + 2 * OUT_HW;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // register map
    localparam logic [LIMIT_W-1:0] CAP_LIMIT_RESET = 5'd16;
    localparam logic               REG_CAP_LIMIT   = 1'b0;

    // request kinds carried in s_tuser
    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_EXECUTE  = 1'b1;

    // status a cell hands to its right neighbor
    typedef struct packed {
        logic valid;   // cell holds an entry
        logic keep;    // entry stays in place on insert (priority >= new)
    } t_cell_link;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

endpackage

### src/ptagd_cell.sv
// ----------------------------------------------------------------------------
// ptagd_cell: one slot of the sorted task chain
// keeps its entry, takes the new entry, or takes its left neighbor's entry
// ----------------------------------------------------------------------------
module ptagd_cell #(
    parameter int HW = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ins,
    input  logic signed [15:0]           i_new_pri,
    input  logic [HW-1:0]                i_new_task,
    input  logic [HW-1:0]                i_new_act,
    input  ptagd_pkg::t_cell_link        i_prev,
    input  logic signed [15:0]           i_prev_pri,
    input  logic [HW-1:0]                i_prev_task,
    input  logic [HW-1:0]                i_prev_act,
    output ptagd_pkg::t_cell_link        o_link,
    output logic signed [15:0]           o_pri,
    output logic [HW-1:0]                o_task,
    output logic [HW-1:0]                o_act
);
    import ptagd_pkg::*;

    logic                r_valid;
    logic signed [15:0]  r_pri;
    logic [HW-1:0]       r_task;
    logic [HW-1:0]       r_act;
    logic                w_keep;

    // equal priorities stay ahead of the newcomer, which keeps order stable
    assign w_keep = r_valid && (r_pri >= i_new_pri);

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ins && !w_keep) begin
            r_valid <= r_valid | i_prev.valid | i_prev.keep;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (i_ins && !w_keep) begin
            if (i_prev.keep) begin
                r_pri  <= i_new_pri;
                r_task <= i_new_task;
                r_act  <= i_new_act;
            end else begin
                r_pri  <= i_prev_pri;
                r_task <= i_prev_task;
                r_act  <= i_prev_act;
            end
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.keep  = w_keep;
    assign o_pri        = r_pri;
    assign o_task       = r_task;
    assign o_act        = r_act;

endmodule

### src/priority_task_agenda_core.sv
// ----------------------------------------------------------------------------
// priority_task_agenda_core: task table emitted by descending priority
// a chain of cells keeps the entries sorted as they register; an execute
// walks the chain and sends every entry out, flagging the last one
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  s_*       in    s_tvalid/s_tready  tuser: kind (0 register, 1 execute);
//                                     tdata: priority, task, action
//  m_*       out   m_tvalid/m_tready  tdata: priority, task, action; tlast
//  apb       in    psel/penable       capacity_limit at byte address 0
//
//  for a register word the chain inserts it in place in parallel
//  an execute of n entries takes n output words, one per cycle when m_tready
//  stays high; the first word is registered on the execute; s_tready is low meanwhile
//  reset clears the cell valid bits and the count at once, no clearing pass
//  an output stall holds the current word and the whole block
// ----------------------------------------------------------------------------
module priority_task_agenda_core #(
    parameter int CAPACITY     = 16,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ptagd_pkg::DATA_W-1:0]  s_tdata,   // priority, task, action
    input  logic                          s_tuser,   // kind
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ptagd_pkg::DATA_W-1:0]  m_tdata,   // priority, task, action
    output logic                          m_tlast,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptagd_pkg::APB_AW-1:0]  paddr,
    input  logic [ptagd_pkg::APB_DW-1:0]  pwdata,
    output logic [ptagd_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import ptagd_pkg::*;

    localparam int KW    = (HANDLE_WIDTH < OUT_HW) ? HANDLE_WIDTH : OUT_HW;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count;
    logic [LIMIT_W-1:0]   r_cap_limit;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_mvalid, n_mvalid;
    logic [DATA_W-1:0]    r_mdata, n_mdata;
    logic                 r_mlast, n_mlast;

    logic                 w_s_acc, w_m_acc, w_ins, w_room, w_load;
    logic signed [15:0]   w_new_pri;
    logic [KW-1:0]        w_new_task, w_new_act;
    logic [IDX_W-1:0]     w_sel;

    t_cell_link           w_link [CAPACITY];
    logic signed [15:0]   w_pri  [CAPACITY];
    logic [KW-1:0]        w_task [CAPACITY];
    logic [KW-1:0]        w_act  [CAPACITY];
    logic [CAPACITY-1:0]  w_valid_vec;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_limit <= CAP_LIMIT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_CAP_LIMIT)) begin
            r_cap_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAP_LIMIT) ? APB_DW'(r_cap_limit) : '0;

    // input decode
    assign s_tready   = (r_state == ST_IDLE);
    assign w_s_acc    = s_tvalid && s_tready;
    assign w_m_acc    = r_mvalid && m_tready;
    assign w_new_pri  = s_tdata[PRI_W-1:0];
    assign w_new_task = s_tdata[PRI_W +: KW];
    assign w_new_act  = s_tdata[PRI_W + OUT_HW +: KW];
    assign w_room     = (CMP_W'(r_count) < CMP_W'(r_cap_limit)) &&
                        (CMP_W'(r_count) < CMP_W'(CAPACITY));
    assign w_ins      = w_s_acc && (s_tuser == REQ_REGISTER) && w_room;

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_ins) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_link          w_prev;
        logic signed [15:0]  w_prev_pri;
        logic [KW-1:0]       w_prev_task, w_prev_act;

        if (g == 0) begin : g_head
            assign w_prev      = '{valid: 1'b0, keep: 1'b1};
            assign w_prev_pri  = '0;
            assign w_prev_task = '0;
            assign w_prev_act  = '0;
        end else begin : g_body
            assign w_prev      = w_link[g-1];
            assign w_prev_pri  = w_pri[g-1];
            assign w_prev_task = w_task[g-1];
            assign w_prev_act  = w_act[g-1];
        end

        ptagd_cell #(
            .HW (KW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ins       (w_ins),
            .i_new_pri   (w_new_pri),
            .i_new_task  (w_new_task),
            .i_new_act   (w_new_act),
            .i_prev      (w_prev),
            .i_prev_pri  (w_prev_pri),
            .i_prev_task (w_prev_task),
            .i_prev_act  (w_prev_act),
            .o_link      (w_link[g]),
            .o_pri       (w_pri[g]),
            .o_task      (w_task[g]),
            .o_act       (w_act[g])
        );

        assign w_valid_vec[g] = w_link[g].valid;
    end

    // emit sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mvalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_mvalid <= n_mvalid;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mdata <= n_mdata;
            r_mlast <= n_mlast;
        end
    end

    // next state, read select and output word
    always_comb begin
        n_state  = r_state;
        n_mvalid = r_mvalid;
        n_idx    = r_idx;
        w_load   = 1'b0;
        w_sel    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_acc && (s_tuser == REQ_EXECUTE) && (r_count != '0)) begin
                    n_state  = ST_EMIT;
                    n_mvalid = 1'b1;
                    n_idx    = '0;
                    w_load   = 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_m_acc) begin
                    if (r_mlast) begin
                        n_state  = ST_IDLE;
                        n_mvalid = 1'b0;
                    end else begin
                        w_sel  = r_idx + IDX_W'(1);
                        n_idx  = w_sel;
                        w_load = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_mdata = {OUT_HW'(w_act[w_sel]), OUT_HW'(w_task[w_sel]), w_pri[w_sel]};
        n_mlast = ((CNT_W + 1)'(w_sel) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(r_count);
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;
    assign m_tlast  = r_mlast;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("cell valid bits disagree with entry count");

    a_exec_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (s_tuser == REQ_EXECUTE) && (r_count != '0)) |=>
            (m_tvalid && (r_idx == '0)))
        else $error("execute did not start emitting from the head");

    a_single_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !s_tready)
        else $error("input accepted while an execute run is in flight");

endmodule

### tb/sv/priority_agenda_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_agenda_checker: predicts and checks the task agenda output stream
// watches the request, output and apb channels of the block, keeps its own
// copy of the task table and limit, and compares every output word against
// the oldest expected entry
// ----------------------------------------------------------------------------
module priority_agenda_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [ptagd_pkg::DATA_W-1:0]  s_tdata,   // priority, task, action
    input  logic                          s_tuser,   // kind
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [ptagd_pkg::DATA_W-1:0]  m_tdata,   // priority, task, action
    input  logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptagd_pkg::APB_AW-1:0]  paddr,
    input  logic [ptagd_pkg::APB_DW-1:0]  pwdata,
    input  logic [ptagd_pkg::APB_DW-1:0]  prdata,
    input  logic                          pready,
    output int                            o_mismatches,
    output int                            o_words_due
);
    import ptagd_pkg::*;

    localparam logic [APB_AW-1:0] CAP_LIMIT_ADDR = APB_AW'(4 * int'(REG_CAP_LIMIT));

    typedef struct packed {
        logic signed [PRI_W-1:0] prio;
        logic [OUT_HW-1:0]       task_id;
        logic [OUT_HW-1:0]       action_id;
    } t_agenda_entry;

    typedef struct packed {
        t_agenda_entry entry;
        logic          last;
    } t_agenda_word;

    // predictor state
    t_agenda_entry      agenda_rows [CAPACITY];
    int                 row_count;
    logic [LIMIT_W-1:0] cap_limit;
    t_agenda_word       due_words [$];

    t_agenda_entry      got_entry;
    t_agenda_word       want_word;

    function automatic int usable_limit();
        return (int'(cap_limit) > CAPACITY) ? CAPACITY : int'(cap_limit);
    endfunction

    function automatic t_agenda_entry unpack_entry(input logic [DATA_W-1:0] d);
        t_agenda_entry e;
        e.prio      = d[PRI_W-1:0];
        e.task_id   = d[PRI_W +: OUT_HW];
        e.action_id = d[PRI_W+OUT_HW +: OUT_HW];
        return e;
    endfunction

    task automatic note_mismatch(input string what);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // stable insertion sort, highest priority first; table stays sorted
    task automatic order_by_priority();
        t_agenda_entry cur;
        int            j;
        for (int i = 1; i < row_count; i++) begin
            cur = agenda_rows[i];
            j = i;
            while (j > 0 && $signed(agenda_rows[j-1].prio) < $signed(cur.prio)) begin
                agenda_rows[j] = agenda_rows[j-1];
                j--;
            end
            agenda_rows[j] = cur;
        end
    endtask

    task automatic predict_request(input logic kind, input logic [DATA_W-1:0] d);
        t_agenda_word w;
        if (kind == REQ_REGISTER) begin
            // full table drops the registration silently
            if (row_count < usable_limit()) begin
                agenda_rows[row_count] = unpack_entry(d);
                row_count++;
            end
        end else begin
            order_by_priority();
            for (int k = 0; k < row_count; k++) begin
                w.entry = agenda_rows[k];
                w.last  = (k == row_count - 1);
                due_words.push_back(w);
            end
        end
    endtask

    initial begin
        o_mismatches = 0;
        o_words_due  = 0;
        row_count    = 0;
        cap_limit    = CAP_LIMIT_RESET;
    end

    // all channels sampled at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_count = 0;
            cap_limit = CAP_LIMIT_RESET;
            due_words.delete();
        end else begin
            // register access
            if (psel && penable && pready && paddr == CAP_LIMIT_ADDR) begin
                if (pwrite) begin
                    cap_limit = pwdata[LIMIT_W-1:0];
                end else if (prdata !== APB_DW'(cap_limit)) begin
                    note_mismatch($sformatf("limit readback expected %0d got %0d",
                                            cap_limit, prdata));
                end
            end
            // accepted request word
            if (s_tvalid && s_tready) begin
                predict_request(s_tuser, s_tdata);
            end
            // accepted output word
            if (m_tvalid && m_tready) begin
                got_entry = unpack_entry(m_tdata);
                if (due_words.size() == 0) begin
                    note_mismatch($sformatf("unexpected word pri %0d task %h action %h",
                                            got_entry.prio, got_entry.task_id,
                                            got_entry.action_id));
                end else begin
                    want_word = due_words.pop_front();
                    if (got_entry.prio !== want_word.entry.prio)
                        note_mismatch($sformatf("priority expected %0d got %0d",
                                                want_word.entry.prio, got_entry.prio));
                    if (got_entry.task_id !== want_word.entry.task_id)
                        note_mismatch($sformatf("task expected %h got %h",
                                                want_word.entry.task_id, got_entry.task_id));
                    if (got_entry.action_id !== want_word.entry.action_id)
                        note_mismatch($sformatf("action expected %h got %h",
                                                want_word.entry.action_id,
                                                got_entry.action_id));
                    if (m_tlast !== want_word.last)
                        note_mismatch($sformatf("tlast expected %b got %b",
                                                want_word.last, m_tlast));
                end
            end
        end
        o_words_due = due_words.size();
    end

endmodule

### tb/sv/tb_priority_task_agenda_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_task_agenda_core: stimulus and verdict for the task agenda
// directed register and execute words across limit settings (zero, one,
// lowered below the count), then random phases up to a saturated limit, with
// ties, extremes and dropped registrations, under random stalls on both
// streams but for one quiet phase
module tb_priority_task_agenda_core;
    import ptagd_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int HANDLE_WIDTH = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam logic [APB_AW-1:0] CAP_LIMIT_ADDR = APB_AW'(4 * int'(REG_CAP_LIMIT));

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata  = '0;     // priority, task, action
    logic                s_tuser  = 1'b0;   // kind
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;           // priority, task, action
    logic                m_tlast;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int   mismatches;
    int   words_due;
    int   cycle_count = 0;
    logic quiet       = 1'b0;   // no idling on either side
    int   rx_stall_left = 0;
    int   rx_roll;

    priority_task_agenda_core #(
        .CAPACITY     (CAPACITY),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    priority_agenda_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_mismatches (mismatches),
        .o_words_due  (words_due)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // output side stalls: mostly short, a few long
    always @(negedge i_clk) begin
        if (quiet) begin
            m_tready = 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_tready = 1'b0;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70) begin
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b0;
                rx_stall_left = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // priorities biased toward ties and extremes
    function automatic logic [PRI_W-1:0] pick_priority();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3: return PRI_W'($urandom);
            4, 5, 6:    return PRI_W'($urandom_range(0, 6) - 3);
            7:          return 16'h7fff;
            8:          return 16'h8000;
            default:    return PRI_W'(-$urandom_range(0, 1));
        endcase
    endfunction

    // one request word, called and returning at a falling edge
    task automatic send_word(input logic kind, input logic [PRI_W-1:0] pri,
                             input logic [OUT_HW-1:0] tid, input logic [OUT_HW-1:0] aid);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tuser  = kind;
        s_tdata  = {aid, tid, pri};
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic register_task(input logic [PRI_W-1:0] pri, input logic [OUT_HW-1:0] tid,
                                 input logic [OUT_HW-1:0] aid);
        send_word(REQ_REGISTER, pri, tid, aid);
    endtask

    task automatic execute_agenda();
        send_word(REQ_EXECUTE, PRI_W'($urandom), OUT_HW'($urandom), OUT_HW'($urandom));
    endtask

    task automatic apb_access(input logic wr, input logic [APB_DW-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = CAP_LIMIT_ADDR;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // write the limit and read it back
    task automatic set_limit(input int value);
        apb_access(1'b1, APB_DW'(value));
        apb_access(1'b0, '0);
    endtask

    // wait out all expected words plus the insert latency
    task automatic settle();
        s_tvalid = 1'b0;
        while (words_due != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_phase(input int n_words, input int exec_pct);
        for (int i = 0; i < n_words; i++) begin
            if ($urandom_range(0, 99) < exec_pct)
                execute_agenda();
            else
                register_task(pick_priority(), OUT_HW'($urandom), OUT_HW'($urandom));
        end
        settle();
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // limit of zero: nothing is stored, execute on empty table is silent
        set_limit(0);
        register_task(16'h7fff, 16'hffff, 16'hffff);
        send_word(REQ_EXECUTE, 16'h8000, 16'h1234, 16'hffff);
        settle();

        // limit of one: second registration dropped
        set_limit(1);
        register_task(16'h8000, 16'h0000, 16'h0000);
        register_task(16'h7fff, 16'hffff, 16'h0000);
        execute_agenda();
        settle();

        // equal priorities keep registration order, extremes at both ends
        set_limit(4);
        register_task(16'd5, 16'h0001, 16'h0002);
        register_task(16'd5, 16'h0003, 16'h0004);
        register_task(16'h7fff, 16'hffff, 16'hffff);
        execute_agenda();
        execute_agenda();
        settle();

        // limit lowered below the count: entries kept, registrations dropped
        set_limit(2);
        register_task(16'hffff, 16'haaaa, 16'h5555);
        execute_agenda();
        settle();

        // random phases, table filling up and then saturating
        set_limit(8);
        random_phase(30, 20);
        quiet = 1'b1;
        set_limit(12);
        random_phase(30, 25);
        quiet = 1'b0;
        set_limit(31);
        random_phase(30, 25);
        set_limit(16);
        random_phase(30, 30);

        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && words_due == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
